/* design/tvg_pkg.sv */
package tvg_pkg;

  localparam int unsigned MaxSegments = 1024;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned CntW        = 11;
  localparam int unsigned DivW        = 43;
  localparam int unsigned QuoW        = 32;
  localparam int unsigned StepW       = 5;

  typedef enum logic [2:0] {
    REG_MAJOR   = 3'd0,
    REG_MINOR   = 3'd1,
    REG_RING    = 3'd2,
    REG_SECTION = 3'd3,
    REG_U_TILE  = 3'd4,
    REG_V_TILE  = 3'd5
  } cfg_reg_e;

  // one step of the long division
  typedef struct packed {
    logic [CntW-1:0] rem;
    logic [DivW-1:0] num;
    logic [QuoW-1:0] quo;
    logic            ov;
  } div_t;

  // one step of the rotation
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [32:0] z;
    logic [1:0]         quad;
  } cor_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [23:0]        tu;
    logic [23:0]        tv;
    logic [20:0]        vn;
    logic               tri_valid;
  } out_t;

  localparam logic [31:0] CordicX0 = 32'h26DD3B6A;
  localparam logic [31:0] PhaseMul = 32'h921FB544;

  localparam logic [31:0] AtanTab [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  function automatic logic [CntW-1:0] eff_count(input logic [CntW-1:0] c);
    logic [CntW-1:0] r;
    r = c;
    if (c == '0) r = CntW'(1);
    else if (c > CntW'(MaxSegments)) r = CntW'(MaxSegments);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 38'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -38'sd2147483648) r = 32'sh80000000;
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [31:0] v);
    logic signed [31:0] r;
    r = v;
    if (v > 32'sd1073741824) r = 32'sd1073741824;
    else if (v < -32'sd1073741824) r = -32'sd1073741824;
    return r;
  endfunction

endpackage

/* design/torus_vertex_generator_core.sv */
// Torus vertex generator.
// Input stream: one word per grid point, ring_index in tdata[10:0], section_index
// in tdata[21:11]. Output stream: one vertex word per input word, in order, with
// position, normal, texture coordinates and vertex number in tdata and the
// triangles-start flag in tuser.
// Configuration: write channel with index and data, always ready; write only while
// no words are in flight.
// Path from input handshake to output word: one input stage, 43
// long-division cells (angle and texture quotients), two angle scaling stages, 16
// rotation cells for sine and cosine, then five stages of clamp, multiply and
// rounding. One word is taken and one given per cycle unless the receiver stalls.
// Reset clears all pipeline valid bits and loads the register defaults (major
// radius 1.0, minor radius 0.25, 16 by 16 segments, tiling 1.0).
// When the receiver stalls, the last word parks in a one-word skid register and
// the whole pipeline holds; s_axis_tready drops until the parked word is taken.
module torus_vertex_generator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ring_index, section_index, zero pad
  input  logic [23:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v, vertex_number, pad
  output logic [215:0] m_axis_tdata,
  // triangles_valid
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned StP1  = tvg_pkg::DivW + 1;
  localparam int unsigned StP2  = StP1 + 1;
  localparam int unsigned StC   = StP2 + tvg_pkg::CordicSteps + 1;
  localparam int unsigned StM1  = StC + 1;
  localparam int unsigned StM2  = StM1 + 1;
  localparam int unsigned StM3  = StM2 + 1;
  localparam int unsigned StOut = StM3 + 1;

  localparam int unsigned CntW = tvg_pkg::CntW;

  logic [30:0]     major_q;
  logic [30:0]     minor_q;
  logic [CntW-1:0] ring_q;
  logic [CntW-1:0] sect_q;
  logic [15:0]     ut_q;
  logic [15:0]     vt_q;

  logic [CntW-1:0] n_eff;
  logic [CntW-1:0] s_eff;

  logic pipe_en;
  logic skid_q;
  logic v_q [StOut+1];

  logic [CntW-1:0] i_q;
  logic [CntW-1:0] j_q;

  assign cfg_ready_o   = 1'b1;
  assign n_eff         = tvg_pkg::eff_count(ring_q);
  assign s_eff         = tvg_pkg::eff_count(sect_q);
  assign pipe_en       = !skid_q;
  assign s_axis_tready = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q <= 31'd65536;
      minor_q <= 31'd16384;
      ring_q  <= 11'd16;
      sect_q  <= 11'd16;
      ut_q    <= 16'd256;
      vt_q    <= 16'd256;
    end else if (cfg_valid_i) begin
      case (tvg_pkg::cfg_reg_e'(cfg_index_i))
        tvg_pkg::REG_MAJOR:   major_q <= cfg_data_i[30:0];
        tvg_pkg::REG_MINOR:   minor_q <= cfg_data_i[30:0];
        tvg_pkg::REG_RING:    ring_q  <= cfg_data_i[CntW-1:0];
        tvg_pkg::REG_SECTION: sect_q  <= cfg_data_i[CntW-1:0];
        tvg_pkg::REG_U_TILE:  ut_q    <= cfg_data_i[15:0];
        tvg_pkg::REG_V_TILE:  vt_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      i_q <= s_axis_tdata[10:0];
      j_q <= s_axis_tdata[21:11];
    end
  end

  // division chains: ring phase, section phase, u and v texture
  tvg_pkg::div_t div_pi [tvg_pkg::DivW+1];
  tvg_pkg::div_t div_pj [tvg_pkg::DivW+1];
  tvg_pkg::div_t div_tu [tvg_pkg::DivW+1];
  tvg_pkg::div_t div_tv [tvg_pkg::DivW+1];

  logic [26:0] tu_prod;
  logic [26:0] tv_prod;

  assign tu_prod = 27'(i_q) * 27'(ut_q);
  assign tv_prod = 27'(j_q) * 27'(vt_q);

  assign div_pi[0] = '{rem: '0, num: {i_q, 32'b0}, quo: '0, ov: 1'b0};
  assign div_pj[0] = '{rem: '0, num: {j_q, 32'b0}, quo: '0, ov: 1'b0};
  assign div_tu[0] = '{rem: '0, num: {8'b0, tu_prod, 8'b0}, quo: '0, ov: 1'b0};
  assign div_tv[0] = '{rem: '0, num: {8'b0, tv_prod, 8'b0}, quo: '0, ov: 1'b0};

  for (genvar g = 0; g < tvg_pkg::DivW; g++) begin : g_div
    tvg_div_cell u_div_pi (
      .clk_i(clk_i), .en_i(pipe_en), .in_i(div_pi[g]), .divisor_i(n_eff),
      .out_o(div_pi[g+1])
    );
    tvg_div_cell u_div_pj (
      .clk_i(clk_i), .en_i(pipe_en), .in_i(div_pj[g]), .divisor_i(s_eff),
      .out_o(div_pj[g+1])
    );
    tvg_div_cell u_div_tu (
      .clk_i(clk_i), .en_i(pipe_en), .in_i(div_tu[g]), .divisor_i(n_eff),
      .out_o(div_tu[g+1])
    );
    tvg_div_cell u_div_tv (
      .clk_i(clk_i), .en_i(pipe_en), .in_i(div_tv[g]), .divisor_i(s_eff),
      .out_o(div_tv[g+1])
    );
  end

  // vertex number and triangle flag, carried to the end
  logic [21:0] vn_full;
  logic [20:0] vn_q  [1:StOut-1];
  logic        tri_q [1:StOut-1];

  assign vn_full = 22'(i_q) * 22'(s_eff + 11'd1) + 22'(j_q);

  // texture, carried from the end of division
  logic [23:0] tu_q [StP1:StOut-1];
  logic [23:0] tv_q [StP1:StOut-1];
  logic [23:0] tu_sat;
  logic [23:0] tv_sat;

  assign tu_sat = (div_tu[tvg_pkg::DivW].ov || div_tu[tvg_pkg::DivW].quo[31:24] != 8'd0) ?
                  24'hFFFFFF : div_tu[tvg_pkg::DivW].quo[23:0];
  assign tv_sat = (div_tv[tvg_pkg::DivW].ov || div_tv[tvg_pkg::DivW].quo[31:24] != 8'd0) ?
                  24'hFFFFFF : div_tv[tvg_pkg::DivW].quo[23:0];

  // angle scaling to radians
  logic [61:0] prod_p;
  logic [61:0] prod_s;
  logic [29:0] rest_p_q, hi_p_q, rest_s_q, hi_s_q;
  logic [1:0]  quad_p_q, quad_s_q;

  assign prod_p = 62'(div_pi[tvg_pkg::DivW].quo[29:0]) * 62'(tvg_pkg::PhaseMul);
  assign prod_s = 62'(div_pj[tvg_pkg::DivW].quo[29:0]) * 62'(tvg_pkg::PhaseMul);

  tvg_pkg::cor_t cor_p [tvg_pkg::CordicSteps+1];
  tvg_pkg::cor_t cor_s [tvg_pkg::CordicSteps+1];
  tvg_pkg::cor_t cor_p0_q;
  tvg_pkg::cor_t cor_s0_q;

  assign cor_p[0] = cor_p0_q;
  assign cor_s[0] = cor_s0_q;

  for (genvar g = 0; g < tvg_pkg::CordicSteps; g++) begin : g_cor
    tvg_cordic_cell u_cor_p (
      .clk_i(clk_i), .en_i(pipe_en), .step_i(tvg_pkg::StepW'(g)), .in_i(cor_p[g]),
      .out_o(cor_p[g+1])
    );
    tvg_cordic_cell u_cor_s (
      .clk_i(clk_i), .en_i(pipe_en), .step_i(tvg_pkg::StepW'(g)), .in_i(cor_s[g]),
      .out_o(cor_s[g+1])
    );
  end

  // quadrant placement
  logic signed [31:0] xp, yp, xs, ys;
  logic signed [31:0] cp_d, sp_d, cs_d, ss_d;
  logic signed [31:0] cp_q, sp_q, cs_q, ss_q;

  always_comb begin
    xp = tvg_pkg::clamp_q30(cor_p[tvg_pkg::CordicSteps].x);
    yp = tvg_pkg::clamp_q30(cor_p[tvg_pkg::CordicSteps].y);
    xs = tvg_pkg::clamp_q30(cor_s[tvg_pkg::CordicSteps].x);
    ys = tvg_pkg::clamp_q30(cor_s[tvg_pkg::CordicSteps].y);
    case (cor_p[tvg_pkg::CordicSteps].quad)
      2'd0: begin cp_d = xp;  sp_d = yp;  end
      2'd1: begin cp_d = -yp; sp_d = xp;  end
      2'd2: begin cp_d = -xp; sp_d = -yp; end
      default: begin cp_d = yp; sp_d = -xp; end
    endcase
    case (cor_s[tvg_pkg::CordicSteps].quad)
      2'd0: begin cs_d = xs;  ss_d = ys;  end
      2'd1: begin cs_d = -ys; ss_d = xs;  end
      2'd2: begin cs_d = -xs; ss_d = -ys; end
      default: begin cs_d = ys; ss_d = -xs; end
    endcase
  end

  // products and rounding
  logic signed [31:0] minor_s;
  logic signed [33:0] major_s;
  logic signed [63:0] rc_d, rs_d, pnx_d, pnz_d;
  logic signed [63:0] rc_q, rs_q, pnx_q, pnz_q;
  logic signed [31:0] ny_full;
  logic signed [15:0] ny_m1_q;
  logic signed [31:0] cp_m1_q, sp_m1_q;

  assign minor_s = $signed({1'b0, minor_q});
  assign major_s = $signed({3'b0, major_q});
  assign rc_d    = minor_s * cs_q;
  assign rs_d    = minor_s * ss_q;
  assign pnx_d   = cs_q * cp_q;
  assign pnz_d   = cs_q * sp_q;
  assign ny_full = (ss_q + 32'sd32768) >>> 16;

  logic signed [63:0] rc_rnd, rs_rnd, nx_rnd, nz_rnd;
  logic signed [33:0] ring_d;
  logic signed [31:0] py_d;
  logic signed [15:0] nx_d, nz_d;
  logic signed [33:0] ring_m2_q;
  logic signed [31:0] py_m2_q, cp_m2_q, sp_m2_q;
  logic signed [15:0] nx_m2_q, ny_m2_q, nz_m2_q;

  always_comb begin
    rc_rnd = (rc_q + 64'sd536870912) >>> 30;
    rs_rnd = (rs_q + 64'sd536870912) >>> 30;
    nx_rnd = (pnx_q + 64'sd35184372088832) >>> 46;
    nz_rnd = -((pnz_q + 64'sd35184372088832) >>> 46);
    ring_d = major_s + rc_rnd[33:0];
    py_d   = tvg_pkg::sat32(rs_rnd[37:0]);
    nx_d   = nx_rnd[15:0];
    nz_d   = nz_rnd[15:0];
  end

  logic signed [65:0] pxp_d, pzp_d, pxp_q, pzp_q;
  logic signed [31:0] py_m3_q;
  logic signed [15:0] nx_m3_q, ny_m3_q, nz_m3_q;

  assign pxp_d = ring_m2_q * cp_m2_q;
  assign pzp_d = ring_m2_q * sp_m2_q;

  logic signed [65:0] px_rnd, pz_rnd;
  tvg_pkg::out_t      out_d;
  tvg_pkg::out_t      out_q;
  tvg_pkg::out_t      skid_data_q;
  tvg_pkg::out_t      m_out;

  always_comb begin
    px_rnd = (pxp_q + 66'sd536870912) >>> 30;
    pz_rnd = -((pzp_q + 66'sd536870912) >>> 30);
    out_d.px        = tvg_pkg::sat32(px_rnd[37:0]);
    out_d.py        = py_m3_q;
    out_d.pz        = tvg_pkg::sat32(pz_rnd[37:0]);
    out_d.nx        = nx_m3_q;
    out_d.ny        = ny_m3_q;
    out_d.nz        = nz_m3_q;
    out_d.tu        = tu_q[StOut-1];
    out_d.tv        = tv_q[StOut-1];
    out_d.vn        = vn_q[StOut-1];
    out_d.tri_valid = tri_q[StOut-1];
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      vn_q[1]  <= vn_full[20:0];
      tri_q[1] <= (i_q < n_eff);
      for (int k = 2; k < StOut; k++) begin
        vn_q[k]  <= vn_q[k-1];
        tri_q[k] <= tri_q[k-1];
      end
      tu_q[StP1] <= tu_sat;
      tv_q[StP1] <= tv_sat;
      for (int k = StP1 + 1; k < StOut; k++) begin
        tu_q[k] <= tu_q[k-1];
        tv_q[k] <= tv_q[k-1];
      end
      rest_p_q <= div_pi[tvg_pkg::DivW].quo[29:0];
      hi_p_q   <= prod_p[61:32];
      quad_p_q <= div_pi[tvg_pkg::DivW].quo[31:30];
      rest_s_q <= div_pj[tvg_pkg::DivW].quo[29:0];
      hi_s_q   <= prod_s[61:32];
      quad_s_q <= div_pj[tvg_pkg::DivW].quo[31:30];
      cor_p0_q <= '{x: tvg_pkg::CordicX0, y: '0,
                    z: {2'b0, 31'(rest_p_q) + 31'(hi_p_q)}, quad: quad_p_q};
      cor_s0_q <= '{x: tvg_pkg::CordicX0, y: '0,
                    z: {2'b0, 31'(rest_s_q) + 31'(hi_s_q)}, quad: quad_s_q};
      cp_q <= cp_d;
      sp_q <= sp_d;
      cs_q <= cs_d;
      ss_q <= ss_d;
      rc_q    <= rc_d;
      rs_q    <= rs_d;
      pnx_q   <= pnx_d;
      pnz_q   <= pnz_d;
      ny_m1_q <= ny_full[15:0];
      cp_m1_q <= cp_q;
      sp_m1_q <= sp_q;
      ring_m2_q <= ring_d;
      py_m2_q <= py_d;
      nx_m2_q <= nx_d;
      ny_m2_q <= ny_m1_q;
      nz_m2_q <= nz_d;
      cp_m2_q <= cp_m1_q;
      sp_m2_q <= sp_m1_q;
      pxp_q   <= pxp_d;
      pzp_q   <= pzp_d;
      py_m3_q <= py_m2_q;
      nx_m3_q <= nx_m2_q;
      ny_m3_q <= ny_m2_q;
      nz_m3_q <= nz_m2_q;
      out_q   <= out_d;
    end
    if (pipe_en && v_q[StOut] && !m_axis_tready) begin
      skid_data_q <= out_q;
    end
  end

  // valid bits and skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= StOut; k++) begin
        v_q[k] <= 1'b0;
      end
      skid_q <= 1'b0;
    end else begin
      if (pipe_en) begin
        v_q[0] <= s_axis_tvalid;
        for (int k = 1; k <= StOut; k++) begin
          v_q[k] <= v_q[k-1];
        end
        if (v_q[StOut] && !m_axis_tready) begin
          skid_q <= 1'b1;
        end
      end else if (m_axis_tready) begin
        skid_q <= 1'b0;
      end
    end
  end

  assign m_out         = skid_q ? skid_data_q : out_q;
  assign m_axis_tvalid = skid_q | v_q[StOut];
  assign m_axis_tdata  = {3'b0, m_out.vn, m_out.tv, m_out.tu, m_out.nz, m_out.ny, m_out.nx,
                          m_out.pz, m_out.py, m_out.px};
  assign m_axis_tuser  = m_out.tri_valid;

`ifndef ASSERT_OFF
  a_skid_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_q && !m_axis_tready) |=> skid_q)
    else $error("parked word lost while stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[0])
    else $error("accepted word not in input stage");

  a_pipe_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |=> $stable(v_q[StOut]))
    else $error("last stage moved while skid full");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_out.ny <= 16'sd16384 && m_out.ny >= -16'sd16384))
    else $error("normal y out of unit range");
`endif

endmodule

/* design/tvg_div_cell.sv */
module tvg_div_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  tvg_pkg::div_t                in_i,
  input  logic [tvg_pkg::CntW-1:0]     divisor_i,
  output tvg_pkg::div_t                out_o
);

  logic [tvg_pkg::CntW:0] rem_ext;
  logic [tvg_pkg::CntW:0] diff;
  logic                   take;
  tvg_pkg::div_t          cell_d;
  tvg_pkg::div_t          cell_q;

  always_comb begin
    rem_ext = {in_i.rem, in_i.num[tvg_pkg::DivW-1]};
    diff    = rem_ext - {1'b0, divisor_i};
    take    = (rem_ext >= {1'b0, divisor_i});
    cell_d.rem = take ? diff[tvg_pkg::CntW-1:0] : rem_ext[tvg_pkg::CntW-1:0];
    cell_d.num = {in_i.num[tvg_pkg::DivW-2:0], 1'b0};
    cell_d.quo = {in_i.quo[tvg_pkg::QuoW-2:0], take};
    cell_d.ov  = in_i.ov | in_i.quo[tvg_pkg::QuoW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

/* design/tvg_cordic_cell.sv */
module tvg_cordic_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [tvg_pkg::StepW-1:0] step_i,
  input  tvg_pkg::cor_t             in_i,
  output tvg_pkg::cor_t             out_o
);

  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [32:0] z;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [32:0] at;
  tvg_pkg::cor_t      cell_d;
  tvg_pkg::cor_t      cell_q;

  always_comb begin
    x  = in_i.x;
    y  = in_i.y;
    z  = in_i.z;
    dx = y >>> step_i;
    dy = x >>> step_i;
    at = $signed({1'b0, tvg_pkg::AtanTab[step_i]});
    cell_d.quad = in_i.quad;
    if (!z[32]) begin
      cell_d.x = x - dx;
      cell_d.y = y + dy;
      cell_d.z = z - at;
    end else begin
      cell_d.x = x + dx;
      cell_d.y = y - dy;
      cell_d.z = z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

/* verif/torus_vertex_generator_core_tb.sv */
`timescale 1ns / 1ps

module torus_vertex_generator_core_tb;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 90;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [215:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  torus_vertex_generator_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // shadow copy of the registers
  logic [30:0] major_r = 31'd65536;
  logic [30:0] minor_r = 31'd16384;
  logic [10:0] ring_n = 11'd16;
  logic [10:0] sect_n = 11'd16;
  logic [15:0] u_rep = 16'd256;
  logic [15:0] v_rep = 16'd256;

  tvg_pkg::out_t vertex_q[$];
  int   fail_count = 0;
  int   burst_left = 0;
  int   cycle_count = 0;

  function automatic longint round_shift(input longint v, input int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned seg_count(input logic [10:0] c);
    if (c == 0) return 64'd1;
    if (c > tvg_pkg::MaxSegments) return 64'(tvg_pkg::MaxSegments);
    return 64'(c);
  endfunction

  function automatic void turn_sincos(input logic [31:0] phase, output longint c,
                                      output longint s);
    longint unsigned rest;
    longint x, y, z, dx, dy, lim;
    rest = 64'(phase[29:0]);
    z = longint'((rest * 64'd6746518852) >> 32);
    x = 64'sh26DD3B6A;
    y = 0;
    for (int k = 0; k < tvg_pkg::CordicSteps; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(tvg_pkg::AtanTab[k]);
      end else begin
        x += dx; y -= dy; z += longint'(tvg_pkg::AtanTab[k]);
      end
    end
    lim = longint'(1) <<< 30;
    x = clip(x, -lim, lim);
    y = clip(y, -lim, lim);
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic tvg_pkg::out_t vertex_of(input logic [10:0] ri, input logic [10:0] si);
    tvg_pkg::out_t v;
    longint unsigned n, s, pi_, pj, tu, tv, ii, jj;
    longint cs, ss, cp, sp, ring, px, py, pz;
    ii = 64'(ri);
    jj = 64'(si);
    n = seg_count(ring_n);
    s = seg_count(sect_n);
    pj = (jj << 32) / s;
    pi_ = (ii << 32) / n;
    turn_sincos(pj[31:0], cs, ss);
    turn_sincos(pi_[31:0], cp, sp);
    ring = longint'({33'd0, major_r}) + round_shift(longint'({33'd0, minor_r}) * cs, 30);
    px = round_shift(ring * cp, 30);
    py = round_shift(longint'({33'd0, minor_r}) * ss, 30);
    pz = -round_shift(ring * sp, 30);
    tu = (ii * u_rep * 256) / n;
    tv = (jj * v_rep * 256) / s;
    if (tu > 64'hFFFFFF) tu = 64'hFFFFFF;
    if (tv > 64'hFFFFFF) tv = 64'hFFFFFF;
    v.px = 32'(clip(px, -64'sd2147483648, 64'sd2147483647));
    v.py = 32'(clip(py, -64'sd2147483648, 64'sd2147483647));
    v.pz = 32'(clip(pz, -64'sd2147483648, 64'sd2147483647));
    v.nx = 16'(round_shift(cs * cp, 46));
    v.ny = 16'(round_shift(ss, 16));
    v.nz = 16'(-round_shift(cs * sp, 46));
    v.tu = tu[23:0];
    v.tv = tv[23:0];
    v.vn = 21'(ii * (s + 1) + jj);
    v.tri_valid = ii < n;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // receiver stalls
  int          rx_mode = 0;
  logic [7:0]  rx_pat = 8'hA5;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 257 == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_pat = 8'($urandom);
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= rx_pat[cycle_count % 8];
    endcase
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    tvg_pkg::out_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (vertex_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[31:0], '0);
      end else begin
        w = vertex_q.pop_front();
        if (m_axis_tdata[31:0] !== w.px) report_mismatch("pos_x", m_axis_tdata[31:0], w.px);
        if (m_axis_tdata[63:32] !== w.py) report_mismatch("pos_y", m_axis_tdata[63:32], w.py);
        if (m_axis_tdata[95:64] !== w.pz) report_mismatch("pos_z", m_axis_tdata[95:64], w.pz);
        if (m_axis_tdata[111:96] !== w.nx)
          report_mismatch("normal_x", m_axis_tdata[111:96], w.nx);
        if (m_axis_tdata[127:112] !== w.ny)
          report_mismatch("normal_y", m_axis_tdata[127:112], w.ny);
        if (m_axis_tdata[143:128] !== w.nz)
          report_mismatch("normal_z", m_axis_tdata[143:128], w.nz);
        if (m_axis_tdata[167:144] !== w.tu)
          report_mismatch("tex_u", m_axis_tdata[167:144], w.tu);
        if (m_axis_tdata[191:168] !== w.tv)
          report_mismatch("tex_v", m_axis_tdata[191:168], w.tv);
        if (m_axis_tdata[212:192] !== w.vn)
          report_mismatch("vertex_number", m_axis_tdata[212:192], w.vn);
        if (m_axis_tuser[0] !== w.tri_valid)
          report_mismatch("triangles_valid", m_axis_tuser[0], w.tri_valid);
      end
    end
  end

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_point(input logic [10:0] ri, input logic [10:0] si);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, si, ri};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    vertex_q.push_back(vertex_of(ri, si));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // holds valid high; cfg_idle drops it after the last write of a group
  task automatic set_reg(input tvg_pkg::cfg_reg_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    case (idx)
      tvg_pkg::REG_MAJOR:   major_r = val[30:0];
      tvg_pkg::REG_MINOR:   minor_r = val[30:0];
      tvg_pkg::REG_RING:    ring_n = val[10:0];
      tvg_pkg::REG_SECTION: sect_n = val[10:0];
      tvg_pkg::REG_U_TILE:  u_rep = val[15:0];
      tvg_pkg::REG_V_TILE:  v_rep = val[15:0];
      default: ;
    endcase
  endtask

  task automatic cfg_idle;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_all(input logic [31:0] maj, input logic [31:0] mnr,
                         input logic [31:0] rn, input logic [31:0] sn,
                         input logic [31:0] ut, input logic [31:0] vt);
    set_reg(tvg_pkg::REG_MAJOR, maj);
    set_reg(tvg_pkg::REG_MINOR, mnr);
    set_reg(tvg_pkg::REG_RING, rn);
    set_reg(tvg_pkg::REG_SECTION, sn);
    set_reg(tvg_pkg::REG_U_TILE, ut);
    set_reg(tvg_pkg::REG_V_TILE, vt);
    cfg_idle();
  endtask

  task automatic test_reset_defaults;
    send_point(11'd0, 11'd0);
    send_point(11'd16, 11'd16);
    send_point(11'd4, 11'd8);
    send_point(11'd15, 11'd3);
    send_point(11'd17, 11'd2047);
    send_point(11'd2047, 11'd0);
    drain();
  endtask

  task automatic test_count_edges;
    // zero counts act as one, oversized counts as the maximum
    set_all(32'hFFFF_0000, 32'd0, 32'd0, 32'hFFFF_F7FF, 32'hFFFF, 32'hFFFF);
    send_point(11'd0, 11'd0);
    send_point(11'd1, 11'd1024);
    send_point(11'd2047, 11'd2047);
    send_point(11'd1, 11'd1023);
    drain();
    set_all(32'd0, 32'h7FFF_FFFF, 32'd1024, 32'd3, 32'd0, 32'd1);
    send_point(11'd1024, 11'd3);
    send_point(11'd1023, 11'd1);
    send_point(11'd512, 11'd2);
    send_point(11'd0, 11'd4);
    drain();
  endtask

  task automatic test_radius_edges;
    // minor equal to and above major, saturating positions and texture
    set_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd3, 32'd1024, 32'hFFFF, 32'hFFFF);
    send_point(11'd0, 11'd0);
    send_point(11'd1, 11'd512);
    send_point(11'd2, 11'd256);
    send_point(11'd3, 11'd768);
    send_point(11'd100, 11'd1024);
    drain();
    set_all(32'd1000, 32'h4000_0000, 32'd7, 32'd5, 32'd300, 32'd77);
    send_point(11'd3, 11'd2);
    send_point(11'd6, 11'd5);
    send_point(11'd7, 11'd0);
    drain();
  endtask

  task automatic test_random_grid;
    logic [10:0] ri, si;
    int unsigned n, s;
    for (int ph = 0; ph < 9; ph++) begin
      set_reg(tvg_pkg::REG_MAJOR,
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 22));
      set_reg(tvg_pkg::REG_MINOR,
              ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20));
      set_reg(tvg_pkg::REG_RING, (ph == 4) ? 32'd1024 : ($urandom_range(0, 4) == 0 ? $urandom
                                                        : $urandom_range(3, 40)));
      set_reg(tvg_pkg::REG_SECTION, (ph == 6) ? 32'd1024 : ($urandom_range(0, 4) == 0 ? $urandom
                                                           : $urandom_range(3, 40)));
      set_reg(tvg_pkg::REG_U_TILE, $urandom);
      set_reg(tvg_pkg::REG_V_TILE, $urandom);
      cfg_idle();
      n = 32'(seg_count(ring_n));
      s = 32'(seg_count(sect_n));
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          ri = 11'($urandom);
          si = 11'($urandom);
        end else begin
          ri = 11'($urandom_range(0, n));
          si = 11'($urandom_range(0, s));
        end
        send_point(ri, si);
      end
      drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_count_edges();
    test_radius_edges();
    test_random_grid();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
